// ----- src/safd_pkg.sv -----
// safd_pkg: shared types, widths, reset values and helpers of the stepper
// angle follow drive. No dependencies; imported by every module of the block.
package safd_pkg;

    localparam int ANGLE_BITS  = 10;
    localparam int PERIOD_BITS = 18;

    localparam int SCALE_W    = 18;
    localparam int CIRC_W     = 11;
    localparam int SPEED_W    = 7;
    localparam int IDLE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(200000);
    localparam logic [CIRC_W-1:0]  CIRC_RST  = CIRC_W'(960);
    localparam logic [SPEED_W-1:0] MAXSP_RST = SPEED_W'(100);
    localparam logic [IDLE_W-1:0]  IDLE_RST  = IDLE_W'(1000);

    // error before saturation: wrapped error up to circle, plain error up to angle range
    localparam int ERR_W = (ANGLE_BITS + 1 > CIRC_W) ? ANGLE_BITS + 1 : CIRC_W;
    // divider serves both the scale division and the angle modulo
    localparam int DIV_W = (SCALE_W > ANGLE_BITS) ? SCALE_W : ANGLE_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    // tick counter must reach both the half period and the idle count
    localparam int CNT_W = (PERIOD_BITS > IDLE_W) ? PERIOD_BITS : IDLE_W;
    localparam int WIDE_W = (DIV_W > PERIOD_BITS) ? DIV_W : PERIOD_BITS;

    localparam logic REQ_ANGLE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_SCALE   = 2'd0,
        CFG_CIRCLE_COUNTS = 2'd1,
        CFG_MAX_SPEED     = 2'd2,
        CFG_IDLE_TICKS    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODSTART,
        ST_MOD,
        ST_WRAP,
        ST_DIV,
        ST_RESULT
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH
    } phase_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic                   tick;
        logic                   speed_nz;
        logic [PERIOD_BITS-1:0] pending_half;
        logic [IDLE_W-1:0]      idle_ticks;
    } pulse_ctl_t;

    // clamp a quotient to the half period width
    function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [DIV_W-1:0] q);
        logic [WIDE_W-1:0] q_wide;
        logic [WIDE_W-1:0] lim;
        logic [WIDE_W-1:0] res;
        q_wide = WIDE_W'(q);
        lim    = WIDE_W'({PERIOD_BITS{1'b1}});
        res    = (q_wide > lim) ? lim : q_wide;
        return res[PERIOD_BITS-1:0];
    endfunction

endpackage

// ----- src/safd_div.sv -----
// safd_div: shared restoring divider, one quotient bit per cycle.
// Depends on safd_pkg (div_req_t, div_rsp_t, DIV_W).
module safd_div (
    input  logic              clk,
    input  logic              rst_n,
    input  safd_pkg::div_req_t req,
    output safd_pkg::div_rsp_t rsp
);
    import safd_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       trial;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // trial subtract; a borrow keeps the shifted remainder
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    // field order: done, quotient, remainder
    assign rsp = {done_reg, quo_reg, rem_reg};

`ifndef SYNTH
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == DIV_CNT_W'(1)) |=> done_reg)
        else $error("divider finished without done");
`endif

endmodule

// ----- src/safd_pulse.sv -----
// safd_pulse: step pulse generator advanced by tick requests (low half, high
// half, idle wait). Depends on safd_pkg (pulse_ctl_t, phase_t, widths).
module safd_pulse (
    input  logic                clk,
    input  logic                rst_n,
    input  safd_pkg::pulse_ctl_t ctl,
    output logic                step_level
);
    import safd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [PERIOD_BITS-1:0] active_reg, active_next;
    logic                   step_reg, step_next;
    logic [CNT_W-1:0]       cnt_inc;
    logic [CNT_W-1:0]       limit;
    logic                   hit;

    assign cnt_inc = count_reg + 1'b1;
    assign limit   = (phase_reg == PH_IDLE) ? CNT_W'(ctl.idle_ticks) : CNT_W'(active_reg);
    assign hit     = (cnt_inc >= limit);

    always_comb
    begin
        phase_next = phase_reg;
        if (ctl.tick && hit)
        begin
            case (phase_reg)
                PH_LOW:  phase_next = PH_HIGH;
                default: phase_next = ctl.speed_nz ? PH_LOW : PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        active_next = active_reg;
        step_next   = step_reg;
        if (ctl.tick)
        begin
            if (!hit)
            begin
                count_next = cnt_inc;
            end
            else
            begin
                count_next = '0;
                case (phase_reg)
                    PH_LOW:
                    begin
                        step_next = 1'b1;
                    end
                    default:
                    begin
                        // period start: latch the new half period
                        if (ctl.speed_nz)
                        begin
                            active_next = ctl.pending_half;
                            step_next   = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            active_reg <= '0;
            step_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    assign step_level = step_reg;

`ifndef SYNTH
    a_rise_from_low: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(step_reg) |-> $past(phase_reg) == PH_LOW)
        else $error("step rose outside the low half");
    a_low_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOW) |-> !step_reg)
        else $error("step high during low half");
    a_hold_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.tick |=> $stable(phase_reg) && $stable(count_reg))
        else $error("pulse state moved without a tick");
`endif

endmodule

// ----- src/stepper_angle_follow_drive_top.sv -----
// stepper_angle_follow_drive_top: request sequencer, configuration registers,
// speed/direction state and output register. Depends on safd_pkg, safd_div, safd_pulse.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   in       | in_valid / in_ready     | req_type, target_angle, measured_angle
//   out      | out_valid / out_ready   | step_level, direction, speed_value
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A tick request does the pulse update, then the result load.
// An angle update makes one pass of the shared divider for the wrap modulo and one
// for pulse_scale/speed; a small circle or a zero speed skips the respective pass.
// One request is in flight at a time; the next is accepted while the previous
// result waits in the output register.
// Reset is asynchronous active low; cfg_ready is always high.
module stepper_angle_follow_drive_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [safd_pkg::ANGLE_BITS-1:0]     target_angle,
    input  logic [safd_pkg::ANGLE_BITS-1:0]     measured_angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                step_level,
    output logic                                direction,
    output logic [safd_pkg::SPEED_W-1:0]        speed_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [safd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [safd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import safd_pkg::*;

    seq_state_t             state_reg, state_next;
    logic [SCALE_W-1:0]     scale_reg;
    logic [CIRC_W-1:0]      circ_reg;
    logic [SPEED_W-1:0]     max_speed_reg;
    logic [IDLE_W-1:0]      idle_reg;

    logic                   neg_reg, neg_next;
    logic [ANGLE_BITS-1:0]  abs_reg, abs_next;
    logic [ANGLE_BITS-1:0]  rem_reg, rem_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic                   dir_reg, dir_next;
    logic [PERIOD_BITS-1:0] pending_reg, pending_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_dir_reg, out_dir_next;
    logic [SPEED_W-1:0]     out_speed_reg, out_speed_next;
    logic                   out_step_reg, out_step_next;

    div_req_t               div_req;
    div_rsp_t               div_rsp;
    pulse_ctl_t             pulse_ctl;
    logic                   pulse_step;

    logic                   in_acc;
    logic                   out_free;
    logic [ANGLE_BITS:0]    diff;
    logic [ANGLE_BITS:0]    mag;
    logic                   circ_big;
    logic [ERR_W-1:0]       r_ext;
    logic [ERR_W-1:0]       circ_ext;
    logic [ERR_W-1:0]       half_ext;
    logic                   wrap;
    logic [ERR_W-1:0]       err;
    logic                   dir_w;
    logic [SPEED_W-1:0]     speed_w;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // signed difference and its magnitude
    assign diff = {1'b0, target_angle} - {1'b0, measured_angle};
    assign mag  = diff[ANGLE_BITS] ? (~diff + 1'b1) : diff;

    // shortest-path wrap of the reduced error
    assign circ_big = (circ_reg >= CIRC_W'(2));
    assign r_ext    = ERR_W'(rem_reg);
    assign circ_ext = ERR_W'(circ_reg);
    assign half_ext = ERR_W'(circ_reg >> 1);
    assign wrap     = circ_big && (r_ext > half_ext);
    assign err      = wrap ? (circ_ext - r_ext) : r_ext;
    assign dir_w    = wrap ? neg_reg : (!neg_reg || (rem_reg == '0));
    assign speed_w  = (err > ERR_W'(max_speed_reg)) ? max_speed_reg : err[SPEED_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (req_type == REQ_TICK) ? ST_RESULT : ST_MODSTART;
                end
            end
            ST_MODSTART: state_next = circ_big ? ST_MOD : ST_WRAP;
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: state_next = (speed_w != '0) ? ST_DIV : ST_RESULT;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        neg_next         = neg_reg;
        abs_next         = abs_reg;
        rem_next         = rem_reg;
        speed_next       = speed_reg;
        dir_next         = dir_reg;
        pending_next     = pending_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_dir_next     = out_dir_reg;
        out_speed_next   = out_speed_reg;
        out_step_next    = out_step_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(abs_reg);
        div_req.divisor  = DIV_W'(circ_reg);
        pulse_ctl.tick         = 1'b0;
        pulse_ctl.speed_nz     = (speed_reg != '0);
        pulse_ctl.pending_half = pending_reg;
        pulse_ctl.idle_ticks   = idle_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        pulse_ctl.tick = 1'b1;
                    end
                    else
                    begin
                        neg_next = diff[ANGLE_BITS];
                        abs_next = mag[ANGLE_BITS-1:0];
                    end
                end
            end
            ST_MODSTART:
            begin
                if (circ_big)
                begin
                    div_req.start = 1'b1;
                end
                else
                begin
                    rem_next = abs_reg;
                end
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    rem_next = div_rsp.remainder[ANGLE_BITS-1:0];
                end
            end
            ST_WRAP:
            begin
                speed_next = speed_w;
                dir_next   = dir_w;
                if (speed_w != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(scale_reg);
                    div_req.divisor  = DIV_W'(speed_w);
                end
                else
                begin
                    pending_next = '0;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    pending_next = sat_period(div_rsp.quotient);
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_dir_next   = dir_reg;
                    out_speed_next = speed_reg;
                    out_step_next  = pulse_step;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= SCALE_RST;
            circ_reg      <= CIRC_RST;
            max_speed_reg <= MAXSP_RST;
            idle_reg      <= IDLE_RST;
            speed_reg     <= '0;
            dir_reg       <= 1'b1;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            speed_reg     <= speed_next;
            dir_reg       <= dir_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PULSE_SCALE:   scale_reg     <= cfg_data[SCALE_W-1:0];
                    CFG_CIRCLE_COUNTS: circ_reg      <= cfg_data[CIRC_W-1:0];
                    CFG_MAX_SPEED:     max_speed_reg <= cfg_data[SPEED_W-1:0];
                    CFG_IDLE_TICKS:    idle_reg      <= cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        abs_reg       <= abs_next;
        rem_reg       <= rem_next;
        out_dir_reg   <= out_dir_next;
        out_speed_reg <= out_speed_next;
        out_step_reg  <= out_step_next;
    end

    safd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    safd_pulse u_pulse (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pulse_ctl),
        .step_level (pulse_step)
    );

    assign out_valid   = out_valid_reg;
    assign step_level  = out_step_reg;
    assign direction   = out_dir_reg;
    assign speed_value = out_speed_reg;

`ifndef SYNTH
    a_tick_short: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && req_type == REQ_TICK) |=> state_reg == ST_RESULT)
        else $error("tick request did not go straight to result");
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_MOD || state_reg == ST_DIV))
        else $error("divider result outside a wait state");
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded into output register");
`endif

endmodule
